FILE: hdl/byte_range_set_update_assert.svh
// Assertion macros used by the checker file
`ifndef BYTE_RANGE_SET_UPDATE_ASSERT_SVH
`define BYTE_RANGE_SET_UPDATE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define BRSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define BRSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/brsu_pkg.sv
package brsu_pkg;
    localparam int MaxRanges = 32;
    localparam int PosBits   = 48;
    localparam int IdxBits   = $clog2(MaxRanges);
    localparam int CntBits   = 6;
    localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_SUB = 1'b1;

    typedef logic [PosBits-1:0] t_pos;
    typedef logic [PosBits:0]   t_end;
    typedef logic [IdxBits-1:0] t_idx;

    // Memory write request from the sequencer
    typedef struct packed {
        logic en;
        t_idx addr;
        t_pos start;
        t_pos size;
    } t_wr;

    function automatic t_pos sat_pos(input t_end v);
        return v[PosBits] ? PosMax : v[PosBits-1:0];
    endfunction
endpackage

FILE: hdl/byte_range_set_update.sv
// Byte range set update.
// Input channel: i_valid/o_stall carries one word (kind, offset, length).
// Kind add extends an adjacent entry and merges at most one neighbour,
// or stores a new entry; kind subtract trims, frees or splits entries.
// Output channel: o_valid/i_stall carries one result word per input word:
// removed bytes, entry count after the operation and a table full flag.
// Steps: subtract runs a split search walk, then an update walk; add runs
// an adjacency walk, then a write-back and a merge partner walk when an
// adjacent entry is found; a finishing state, then the output register.
// Rate is set by the single read port of the entry memory, one entry read
// per cycle; one word is in work at a time.
// The result sits in an output register; the next word is taken while it
// waits to be taken, and held in work until the register is free.
// Reset empties the table at once through per-slot valid bits; no
// clearing pass is needed. A stalled result holds its value.
module byte_range_set_update import brsu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic         i_kind,
    input  logic [47:0]  i_range_offset,
    input  logic [47:0]  i_range_length,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [47:0]  o_removed_bytes,
    output logic [5:0]   o_entry_count,
    output logic         o_table_full
);
    t_wr  wr;
    t_idx raddr;
    t_pos rd_start, rd_size, removed;
    logic done, full, busy, r_busy, n_busy, go;
    logic [CntBits-1:0] cnt;

    // Accept when no word is in work
    assign o_stall = r_busy;
    assign go = i_valid && !r_busy;

    brsu_ram u_ram (
        .i_clk(i_clk), .i_wr(wr), .i_raddr(raddr),
        .o_start(rd_start), .o_size(rd_size)
    );

    brsu_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_hold(busy), .i_kind(i_kind),
        .i_off(i_range_offset), .i_len(i_range_length),
        .i_rd_start(rd_start), .i_rd_size(rd_size),
        .o_raddr(raddr), .o_wr(wr), .o_done(done),
        .o_removed(removed), .o_count(cnt), .o_full(full)
    );

    // Output register occupied and stalled
    assign busy = o_valid && i_stall;
    // Busy from accept until the result is loaded into the output register
    always_comb begin
        n_busy = r_busy;
        if (go) n_busy = 1'b1;
        if (done && !busy) n_busy = 1'b0;
    end

    // Track busy and load the result once the output register frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (done && !busy) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
        end
        if (done && !busy) begin
            o_removed_bytes <= removed;
            o_entry_count   <= cnt;
            o_table_full    <= full;
        end
    end
endmodule

FILE: hdl/brsu_ram.sv
module brsu_ram import brsu_pkg::*; (
    input  logic i_clk,
    input  t_wr  i_wr,
    input  t_idx i_raddr,
    output t_pos o_start,
    output t_pos o_size
);
    t_pos r_start [MaxRanges];
    t_pos r_size  [MaxRanges];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_start[i_wr.addr] <= i_wr.start;
            r_size[i_wr.addr]  <= i_wr.size;
        end
        o_start <= r_start[i_raddr];
        o_size  <= r_size[i_raddr];
    end
endmodule

FILE: hdl/brsu_seq.sv
module brsu_seq import brsu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic         i_hold,
    input  logic         i_kind,
    input  t_pos         i_off,
    input  t_pos         i_len,
    input  t_pos         i_rd_start,
    input  t_pos         i_rd_size,
    output t_idx         o_raddr,
    output t_wr          o_wr,
    output logic         o_done,
    output t_pos         o_removed,
    output logic [CntBits-1:0] o_count,
    output logic         o_full
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,  // subtract: find split entry
        S_SUB   = 9'b000000100,  // subtract: main walk
        S_ADD1  = 9'b000001000,  // add: find adjacent entry
        S_ADDW  = 9'b000010000,  // unused, never entered
        S_ADD2  = 9'b000100000,  // add: find merge partner
        S_DONE  = 9'b001000000,
        S_HITRD = 9'b010000000,
        S_HITWR = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [MaxRanges-1:0] r_valid, n_valid;
    logic [CntBits:0] r_cnt, n_cnt;
    logic [IdxBits:0] r_ptr, n_ptr;
    logic r_rdv, n_rdv;
    t_idx r_ridx, n_ridx;
    logic r_kind, n_kind;
    t_pos r_off, n_off, r_len, n_len;
    t_end r_end, n_end;
    logic r_splitv, n_splitv;
    t_idx r_split, n_split;
    t_idx r_slot, n_slot;
    logic r_slotv, n_slotv;
    t_pos r_tot, n_tot;
    t_idx r_hit, n_hit;
    t_pos r_hs, n_hs, r_hz, n_hz;
    logic r_full, n_full;
    t_wr  w;
    t_end e, tsum;
    logic free_v;
    t_idx free_i;

    // Lowest free slot from valid bits
    always_comb begin
        free_v = 1'b0;
        free_i = '0;
        for (int k = MaxRanges - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_v = 1'b1;
                free_i = t_idx'(k);
            end
        end
    end

    assign e = {1'b0, i_rd_start} + {1'b0, i_rd_size};

    always_comb begin
        n_state = r_state; n_valid = r_valid; n_cnt = r_cnt; n_ptr = r_ptr;
        n_rdv = 1'b0; n_ridx = r_ptr[IdxBits-1:0]; n_kind = r_kind;
        n_off = r_off; n_len = r_len; n_end = r_end;
        n_splitv = r_splitv; n_split = r_split; n_slot = r_slot; n_slotv = r_slotv;
        n_tot = r_tot; n_hit = r_hit; n_hs = r_hs; n_hz = r_hz; n_full = r_full;
        w = '0;
        tsum = '0;
        o_raddr = r_ptr[IdxBits-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_kind = i_kind; n_off = i_off; n_len = i_len;
                    n_end = {1'b0, i_off} + {1'b0, i_len};
                    n_tot = '0; n_full = 1'b0; n_splitv = 1'b0; n_ptr = '0;
                    n_slot = free_i; n_slotv = free_v;
                    if (i_kind == KIND_SUB) n_state = S_SCAN;
                    else if (i_len == '0) n_state = S_DONE;
                    else n_state = S_ADD1;
                end
            end
            S_SCAN, S_SUB, S_ADD1, S_ADD2: begin
                // Issue read at pointer, evaluate previous read
                if (r_ptr < (IdxBits+1)'(MaxRanges)) begin
                    n_rdv = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                end
                if (r_rdv && r_valid[r_ridx]) begin
                    if (r_state == S_SCAN) begin
                        if (!r_splitv && {1'b0, r_off} > {1'b0, i_rd_start}
                            && r_end < e) begin
                            n_splitv = 1'b1; n_split = r_ridx;
                        end
                    end else if (r_state == S_SUB) begin
                        if ({1'b0, r_off} <= {1'b0, i_rd_start} && r_end >= e) begin
                            n_valid[r_ridx] = 1'b0; n_cnt = r_cnt - 1'b1;
                            tsum = {1'b0, r_tot} + {1'b0, i_rd_size};
                        end else if (r_splitv && r_ridx == r_split) begin
                            n_valid[r_slot] = 1'b1; n_cnt = r_cnt + 1'b1;
                            n_hit = r_slot;
                            n_hs = sat_pos(r_end);
                            n_hz = t_pos'(e - r_end);
                            w.en = 1'b1; w.addr = r_ridx; w.start = i_rd_start;
                            w.size = t_pos'({1'b0, r_off} - {1'b0, i_rd_start});
                            tsum = {1'b0, r_tot} + {1'b0, r_len};
                            n_rdv = 1'b0; n_state = S_HITWR;
                        end else if (r_end > {1'b0, i_rd_start} && r_end < e) begin
                            w.en = 1'b1; w.addr = r_ridx; w.start = sat_pos(r_end);
                            w.size = t_pos'(e - r_end);
                            tsum = {1'b0, r_tot} + (r_end - {1'b0, i_rd_start});
                        end else if ({1'b0, r_off} > {1'b0, i_rd_start}
                                     && {1'b0, r_off} < e) begin
                            w.en = 1'b1; w.addr = r_ridx; w.start = i_rd_start;
                            w.size = t_pos'({1'b0, r_off} - {1'b0, i_rd_start});
                            tsum = {1'b0, r_tot} + (e - {1'b0, r_off});
                        end else begin
                            tsum = {1'b0, r_tot};
                        end
                        n_tot = sat_pos(tsum);
                    end else if (r_state == S_ADD1) begin
                        if (e == {1'b0, r_off}) begin
                            n_hit = r_ridx; n_hs = i_rd_start;
                            n_hz = sat_pos({1'b0, i_rd_size} + {1'b0, r_len});
                            n_rdv = 1'b0; n_state = S_HITRD;
                        end else if (r_end == {1'b0, i_rd_start}) begin
                            n_hit = r_ridx; n_hs = r_off;
                            n_hz = sat_pos({1'b0, i_rd_size} + {1'b0, r_len});
                            n_rdv = 1'b0; n_state = S_HITRD;
                        end
                    end else if (r_ridx != r_hit) begin
                        if ({1'b0, r_hs} + {1'b0, r_hz} == {1'b0, i_rd_start}) begin
                            n_hz = sat_pos({1'b0, r_hz} + {1'b0, i_rd_size});
                            n_valid[r_ridx] = 1'b0; n_cnt = r_cnt - 1'b1;
                            n_rdv = 1'b0; n_state = S_HITWR;
                        end else if (e == {1'b0, r_hs}) begin
                            n_hs = i_rd_start;
                            n_hz = sat_pos({1'b0, r_hz} + {1'b0, i_rd_size});
                            n_valid[r_ridx] = 1'b0; n_cnt = r_cnt - 1'b1;
                            n_rdv = 1'b0; n_state = S_HITWR;
                        end
                    end
                end
                // End of walk
                if (n_state == r_state && !n_rdv && r_ptr == (IdxBits+1)'(MaxRanges)) begin
                    n_ptr = '0;
                    if (r_state == S_SCAN) begin
                        if (n_splitv && !r_slotv) begin
                            n_full = 1'b1; n_state = S_DONE;
                        end else n_state = S_SUB;
                    end else if (r_state == S_ADD1) begin
                        if (!r_slotv) begin
                            n_full = 1'b1;
                        end else begin
                            w.en = 1'b1; w.addr = r_slot; w.start = r_off; w.size = r_len;
                            n_valid[r_slot] = 1'b1; n_cnt = r_cnt + 1'b1;
                        end
                        n_state = S_DONE;
                    end else n_state = S_DONE;
                end
            end
            S_HITRD: begin
                // Write extended hit entry, then walk for a merge partner
                w.en = 1'b1; w.addr = r_hit; w.start = r_hs; w.size = r_hz;
                n_ptr = '0; n_state = S_ADD2;
            end
            S_HITWR: begin
                w.en = 1'b1; w.addr = r_hit; w.start = r_hs; w.size = r_hz;
                n_state = S_DONE;
            end
            // Hold the result until the output register can take it
            S_DONE: if (!i_hold) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_cnt <= '0; r_ptr <= '0; r_rdv <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_cnt <= n_cnt;
            r_ptr <= n_ptr; r_rdv <= n_rdv;
        end
        r_ridx <= n_ridx; r_kind <= n_kind; r_off <= n_off; r_len <= n_len;
        r_end <= n_end; r_splitv <= n_splitv; r_split <= n_split; r_slot <= n_slot;
        r_slotv <= n_slotv; r_tot <= n_tot; r_hit <= n_hit; r_hs <= n_hs;
        r_hz <= n_hz; r_full <= n_full;
    end

    assign o_wr      = w;
    assign o_done    = (r_state == S_DONE);
    assign o_removed = (r_kind == KIND_SUB && !r_full) ? r_tot : '0;
    assign o_count   = r_cnt[CntBits-1:0];
    assign o_full    = r_full;
endmodule

FILE: hdl/brsu_check.sv
`include "byte_range_set_update_assert.svh"
module brsu_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [47:0] o_removed_bytes,
    input logic [5:0]  o_entry_count,
    input logic        o_table_full
);
    `BRSU_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_removed_bytes))
    `BRSU_ASSERT_IMP(a_cnt, i_clk, i_rst_n, o_valid, o_entry_count <= 6'd32)
    `BRSU_ASSERT_NXT(a_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

bind byte_range_set_update brsu_check u_check (.*);

FILE: dv/tb_top.sv
module tb_top;
    import brsu_pkg::*;

    typedef struct {
        logic        kind;
        logic [47:0] offset;
        logic [47:0] length;
    } t_word;

    typedef struct {
        logic [47:0] removed;
        logic [5:0]  count;
        logic        full;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = KIND_ADD;
    logic [47:0] i_range_offset = '0;
    logic [47:0] i_range_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [47:0] o_removed_bytes;
    logic [5:0]  o_entry_count;
    logic        o_table_full;

    byte_range_set_update uut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: mirror of the range table
    logic [47:0] tab_start [MaxRanges];
    logic [47:0] tab_size [MaxRanges];
    logic        tab_valid [MaxRanges];
    int          tab_count;

    t_word   pending_words [$];
    t_result expected_results [$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      splits_seen = 0;
    int      fulls_seen = 0;
    bit      quiet_phase = 0;
    bit      hold_receiver = 0;
    int      send_gap = 0;
    int      recv_gap = 0;

    // Acceptance seen at the rising edge, consumed at the next falling edge
    logic  o_stall_q = 1'b1;
    t_word word_q;

    function automatic logic [47:0] clip_pos(logic [48:0] v);
        return v[48] ? PosMax : v[47:0];
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < MaxRanges; i++)
            if (!tab_valid[i]) return i;
        return -1;
    endfunction

    // Apply one word to the table mirror and return its result
    function automatic t_result apply_word(t_word w);
        t_result r;
        logic [48:0] stop, e, tot;
        int split, slot, hit;
        r.removed = '0;
        r.full = 1'b0;
        stop = {1'b0, w.offset} + w.length;
        if (w.kind == KIND_SUB) begin
            split = -1;
            tot = '0;
            for (int i = 0; i < MaxRanges; i++)
                if (tab_valid[i] && w.offset > tab_start[i] &&
                        stop < {1'b0, tab_start[i]} + tab_size[i]) begin
                    split = i;
                    break;
                end
            slot = first_free_slot();
            if (split >= 0 && slot < 0) begin
                r.full = 1'b1;
            end else begin
                if (split >= 0) splits_seen++;
                for (int i = 0; i < MaxRanges; i++) begin
                    if (!tab_valid[i]) continue;
                    e = {1'b0, tab_start[i]} + tab_size[i];
                    if (w.offset <= tab_start[i] && stop >= e) begin
                        tab_valid[i] = 1'b0;
                        tab_count--;
                        tot = tot + tab_size[i];
                    end else if (i == split) begin
                        tab_valid[slot] = 1'b1;
                        tab_start[slot] = clip_pos(stop);
                        tab_size[slot] = 48'(e - stop);
                        tab_count++;
                        tab_size[i] = w.offset - tab_start[i];
                        tot = tot + w.length;
                        tot = {1'b0, clip_pos(tot)};
                        break;
                    end else if (stop > tab_start[i] && stop < e) begin
                        tot = tot + (stop - tab_start[i]);
                        tab_size[i] = 48'(e - stop);
                        tab_start[i] = clip_pos(stop);
                    end else if (w.offset > tab_start[i] && w.offset < e) begin
                        tot = tot + (e - w.offset);
                        tab_size[i] = w.offset - tab_start[i];
                    end
                    tot = {1'b0, clip_pos(tot)};
                end
                r.removed = clip_pos(tot);
            end
        end else if (w.length != 0) begin
            hit = -1;
            for (int i = 0; i < MaxRanges; i++) begin
                if (!tab_valid[i]) continue;
                if ({1'b0, tab_start[i]} + tab_size[i] == {1'b0, w.offset}) begin
                    tab_size[i] = clip_pos({1'b0, tab_size[i]} + w.length);
                    hit = i;
                    break;
                end
                if (stop == {1'b0, tab_start[i]}) begin
                    tab_start[i] = w.offset;
                    tab_size[i] = clip_pos({1'b0, tab_size[i]} + w.length);
                    hit = i;
                    break;
                end
            end
            if (hit < 0) begin
                slot = first_free_slot();
                if (slot < 0) begin
                    r.full = 1'b1;
                end else begin
                    tab_valid[slot] = 1'b1;
                    tab_start[slot] = w.offset;
                    tab_size[slot] = w.length;
                    tab_count++;
                end
            end else begin
                for (int i = 0; i < MaxRanges; i++) begin
                    if (i == hit || !tab_valid[i]) continue;
                    if ({1'b0, tab_start[hit]} + tab_size[hit] == {1'b0, tab_start[i]})
                    begin
                        tab_size[hit] = clip_pos({1'b0, tab_size[hit]} + tab_size[i]);
                    end else if ({1'b0, tab_start[i]} + tab_size[i] ==
                            {1'b0, tab_start[hit]}) begin
                        tab_start[hit] = tab_start[i];
                        tab_size[hit] = clip_pos({1'b0, tab_size[hit]} + tab_size[i]);
                    end else begin
                        continue;
                    end
                    tab_valid[i] = 1'b0;
                    tab_count--;
                    break;
                end
            end
        end
        if (r.full) fulls_seen++;
        r.count = 6'(tab_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch on result %0d: %s got %0h, want %0h", results_seen, what,
            got, want);
        mismatches++;
    endtask

    task automatic queue_word(logic kind, logic [47:0] offset, logic [47:0] length);
        t_word w;
        w.kind = kind;
        w.offset = offset;
        w.length = length;
        pending_words.push_back(w);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // Drive: present the head word, hold it while stalled, idle in bursts
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall_q) begin
                void'(pending_words.pop_front());
                expected_results.push_back(apply_word(word_q));
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (!(i_valid && o_stall_q) && !quiet_phase &&
                    $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 19);
                i_valid <= 1'b0;
            end else if (i_valid && o_stall_q) begin
                i_valid <= 1'b1;
            end else if (pending_words.size() > (i_valid && !o_stall_q ? 0 : 0)) begin
                i_valid <= 1'b1;
                i_kind <= pending_words[0].kind;
                i_range_offset <= pending_words[0].offset;
                i_range_length <= pending_words[0].length;
                word_q <= pending_words[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) o_stall_q <= o_stall;

    // Receiver stall in bursts, or a long hold when asked
    always @(negedge i_clk) begin
        if (hold_receiver) begin
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= 1'b1;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 18);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result word", o_removed_bytes, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_removed_bytes !== want.removed)
                    report_mismatch("removed_bytes", o_removed_bytes, want.removed);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", 48'(o_entry_count), 48'(want.count));
                if (o_table_full !== want.full)
                    report_mismatch("table_full", 48'(o_table_full), 48'(want.full));
            end
            results_seen++;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Random word: mostly ranges that touch or cut existing entries
    task automatic queue_random(int n);
        int pick;
        logic [47:0] base;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            base = 48'(($urandom_range(0, 63)) * 16);
            case (pick)
                0: queue_word(1'($urandom_range(0, 1)), rand48(), rand48());
                1: queue_word(1'($urandom_range(0, 1)),
                    PosMax - 48'($urandom_range(0, 40)),
                    $urandom_range(0, 1) ? PosMax : 48'($urandom_range(0, 40)));
                default: queue_word($urandom_range(0, 2) == 0,
                    base + 48'($urandom_range(0, 15)),
                    48'($urandom_range(0, 40)));
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < MaxRanges; i++) begin
            tab_valid[i] = 1'b0;
            tab_start[i] = '0;
            tab_size[i] = '0;
        end
        tab_count = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, merges, splits, zero lengths, empty subtract
        queue_word(KIND_SUB, 48'd100, 48'd10);
        queue_word(KIND_ADD, 48'd100, 48'd0);
        queue_word(KIND_ADD, 48'd100, 48'd10);
        queue_word(KIND_ADD, 48'd120, 48'd10);
        queue_word(KIND_ADD, 48'd110, 48'd10);
        queue_word(KIND_ADD, 48'd90, 48'd10);
        queue_word(KIND_SUB, 48'd105, 48'd0);
        queue_word(KIND_SUB, 48'd110, 48'd5);
        queue_word(KIND_SUB, 48'd80, 48'd15);
        queue_word(KIND_SUB, 48'd125, 48'd50);
        queue_word(KIND_SUB, 48'd0, PosMax);
        queue_word(KIND_ADD, PosMax, PosMax);
        queue_word(KIND_ADD, 48'd0, PosMax);
        queue_word(KIND_SUB, 48'd1, 48'd2);
        queue_word(KIND_SUB, 48'd0, PosMax);
        for (int i = 0; i < MaxRanges + 1; i++)
            queue_word(KIND_ADD, 48'(i * 10), 48'd5);
        queue_word(KIND_SUB, 48'd1, 48'd1);
        queue_word(KIND_ADD, 48'd5, 48'd5);
        wait_drained();

        // Fill the block while the receiver holds off
        hold_receiver = 1;
        queue_random(20);
        repeat (600) @(posedge i_clk);
        hold_receiver = 0;
        wait_drained();

        queue_random(200);
        wait_drained();
        queue_word(KIND_SUB, 48'd0, PosMax);
        queue_random(200);
        wait_drained();
        quiet_phase = 1;
        queue_random(60);
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("%0d results checked, %0d splits, %0d full-table cases, %0d mismatches",
            results_seen, splits_seen, fulls_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** byte_range_set_update: PASSED **");
        else
            $display("** byte_range_set_update: FAILED **");
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("** byte_range_set_update: FAILED **");
        $finish;
    end
endmodule
